### hw/rtl/qvr_pkg.sv
// Package for the quaternion vector rotation block: widths, stream payload
// types and the stage enable bundle shared by the top level and the datapath.
// No dependencies.
package qvr_pkg;

    // Width of every quaternion, vector and result component.
    localparam int COMPONENT_BITS = 16;

    // Quaternion fraction bits twice over: the scale of q * v * conj(q).
    localparam int FRAC_SHIFT = 2 * (COMPONENT_BITS - 2);

    // The arithmetic is defined modulo 2^64, so no intermediate exceeds that.
    localparam int WRAP_W = 64;

    // Width of a component by component product in the first Hamilton product.
    localparam int PROD_W = 2 * COMPONENT_BITS;
    // Three products summed.
    localparam int T_W = (PROD_W + 2 > WRAP_W) ? WRAP_W : PROD_W + 2;
    // Products in the second Hamilton product.
    localparam int P2_W = (T_W + COMPONENT_BITS > WRAP_W) ? WRAP_W : T_W + COMPONENT_BITS;
    // Four products summed.
    localparam int U_W = (P2_W + 2 > WRAP_W) ? WRAP_W : P2_W + 2;
    // Width left after the fraction shift, and the width used for clamping.
    localparam int R_W = U_W - FRAC_SHIFT;
    localparam int RX_W = (R_W > COMPONENT_BITS) ? R_W : COMPONENT_BITS;

    // Pipeline depth from request acceptance to result register.
    localparam int NUM_STAGES = 5;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((7 * COMPONENT_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * COMPONENT_BITS + 7) / 8) * 8;

    typedef logic signed [COMPONENT_BITS-1:0] comp_t;

    typedef struct packed {
        comp_t vec_z;
        comp_t vec_y;
        comp_t vec_x;
        comp_t quat_z;
        comp_t quat_y;
        comp_t quat_x;
        comp_t quat_w;
    } qvr_in_t;

    typedef struct packed {
        logic  saturated;
        comp_t rot_z;
        comp_t rot_y;
        comp_t rot_x;
    } qvr_out_t;

    // Load enables for the datapath registers, one per stage.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } qvr_ctrl_t;

endpackage

### hw/rtl/qvr_datapath.sv
// Datapath of the quaternion vector rotation: two Hamilton products split into
// product and sum stages, then the fraction shift and clamp. Uses qvr_pkg.
module qvr_datapath
    import qvr_pkg::*;
(
    input  logic      aclk,
    input  qvr_ctrl_t ctrl,
    input  qvr_in_t   din,
    output qvr_out_t  dout
);

    localparam logic signed [RX_W-1:0] HI_X =
        RX_W'($signed({1'b0, {(COMPONENT_BITS-1){1'b1}}}));
    localparam logic signed [RX_W-1:0] LO_X =
        RX_W'($signed({1'b1, {(COMPONENT_BITS-1){1'b0}}}));

    // Stage 1: products of quaternion and vector components.
    logic signed [PROD_W-1:0] p_reg [12];
    logic signed [PROD_W-1:0] p_next [12];
    comp_t q1_reg [4];

    // Stage 2: first product t = q * (0, v).
    logic signed [T_W-1:0] t_reg [4];
    logic signed [T_W-1:0] t_next [4];
    comp_t q2_reg [4];

    // Stage 3: products of t with the conjugate.
    logic signed [P2_W-1:0] a_reg [12];
    logic signed [P2_W-1:0] a_next [12];

    // Stage 4: vector part of t * conj(q).
    logic signed [U_W-1:0] u_reg [3];
    logic signed [U_W-1:0] u_next [3];

    // Stage 5: clamped result.
    qvr_out_t out_reg;
    qvr_out_t out_next;

    always_comb begin
        p_next[0]  = din.quat_x * din.vec_x;
        p_next[1]  = din.quat_y * din.vec_y;
        p_next[2]  = din.quat_z * din.vec_z;
        p_next[3]  = din.quat_w * din.vec_x;
        p_next[4]  = din.quat_w * din.vec_y;
        p_next[5]  = din.quat_w * din.vec_z;
        p_next[6]  = din.quat_y * din.vec_z;
        p_next[7]  = din.quat_z * din.vec_y;
        p_next[8]  = din.quat_z * din.vec_x;
        p_next[9]  = din.quat_x * din.vec_z;
        p_next[10] = din.quat_x * din.vec_y;
        p_next[11] = din.quat_y * din.vec_x;
    end

    always_comb begin
        t_next[0] = T_W'(0) - (T_W'(p_reg[0]) + T_W'(p_reg[1]) + T_W'(p_reg[2]));
        t_next[1] = T_W'(p_reg[3]) + (T_W'(p_reg[6]) - T_W'(p_reg[7]));
        t_next[2] = T_W'(p_reg[4]) + (T_W'(p_reg[8]) - T_W'(p_reg[9]));
        t_next[3] = T_W'(p_reg[5]) + (T_W'(p_reg[10]) - T_W'(p_reg[11]));
    end

    // The conjugate negates x, y and z; the signs are applied in the sums so
    // that the most negative component needs no extra bit.
    always_comb begin
        a_next[0]  = t_reg[0] * q2_reg[1];
        a_next[1]  = t_reg[1] * q2_reg[0];
        a_next[2]  = t_reg[2] * q2_reg[3];
        a_next[3]  = t_reg[3] * q2_reg[2];
        a_next[4]  = t_reg[0] * q2_reg[2];
        a_next[5]  = t_reg[2] * q2_reg[0];
        a_next[6]  = t_reg[3] * q2_reg[1];
        a_next[7]  = t_reg[1] * q2_reg[3];
        a_next[8]  = t_reg[0] * q2_reg[3];
        a_next[9]  = t_reg[3] * q2_reg[0];
        a_next[10] = t_reg[1] * q2_reg[2];
        a_next[11] = t_reg[2] * q2_reg[1];
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u_next[k] = (U_W'(a_reg[4*k+1]) - U_W'(a_reg[4*k]))
                      + (U_W'(a_reg[4*k+3]) - U_W'(a_reg[4*k+2]));
        end
    end

    always_comb begin
        logic signed [RX_W-1:0] r_ext [3];
        logic [2:0]             clamp;
        comp_t                  r_val [3];
        for (int k = 0; k < 3; k++) begin
            r_ext[k] = RX_W'($signed(u_reg[k][U_W-1:FRAC_SHIFT]));
            if (r_ext[k] > HI_X) begin
                r_val[k] = HI_X[COMPONENT_BITS-1:0];
                clamp[k] = 1'b1;
            end else if (r_ext[k] < LO_X) begin
                r_val[k] = LO_X[COMPONENT_BITS-1:0];
                clamp[k] = 1'b1;
            end else begin
                r_val[k] = r_ext[k][COMPONENT_BITS-1:0];
                clamp[k] = 1'b0;
            end
        end
        out_next.rot_x     = r_val[0];
        out_next.rot_y     = r_val[1];
        out_next.rot_z     = r_val[2];
        out_next.saturated = |clamp;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            p_reg     <= p_next;
            q1_reg[0] <= din.quat_w;
            q1_reg[1] <= din.quat_x;
            q1_reg[2] <= din.quat_y;
            q1_reg[3] <= din.quat_z;
        end
        if (ctrl.load[1]) begin
            t_reg  <= t_next;
            q2_reg <= q1_reg;
        end
        if (ctrl.load[2]) begin
            a_reg <= a_next;
        end
        if (ctrl.load[3]) begin
            u_reg <= u_next;
        end
        if (ctrl.load[4]) begin
            out_reg <= out_next;
        end
    end

    assign dout = out_reg;

endmodule

### hw/rtl/quaternion_vector_rotate_top.sv
// Top level of the quaternion vector rotation: stream ports, stage valid bits
// and flow control around qvr_datapath. Uses qvr_pkg.
//
// Usage: each request on the s_axis channel carries a quaternion in Q2.14 and
// a signed vector; one result per request leaves on the m_axis channel with
// the rotated vector q * v * conj(q), shifted down by 28 bits and clamped to
// 16 bits. m_axis_tuser flags that at least one component was clamped. The
// quaternion is used as given, so a non-unit quaternion scales the result.
// The pipeline takes one request per cycle while the receiver keeps up. The
// five stages are the quaternion-vector multipliers, the first product sums,
// the multipliers of the second product, its sums, and the shift and clamp
// into the result register. Each stage moves when the stage after it is
// empty or moving, so a stalled receiver fills empty stages first and only
// then drops s_axis_tready; nothing is lost or repeated. Reset clears all
// valid bits.
module quaternion_vector_rotate_top
    import qvr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z from bit 0 up
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // rot_x, rot_y, rot_z from bit 0 up, then zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // saturated
    output logic [0:0]           m_axis_tuser
);

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] rdy;
    qvr_ctrl_t             ctrl;
    qvr_in_t               din;
    qvr_out_t              dout;

    // A stage can take new data when it is empty or its content moves on.
    always_comb begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign ctrl.load = rdy;
    assign din       = qvr_in_t'(s_axis_tdata[7*COMPONENT_BITS-1:0]);

    qvr_datapath u_datapath (
        .aclk (aclk),
        .ctrl (ctrl),
        .din  (din),
        .dout (dout)
    );

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];
    assign m_axis_tdata  = M_TDATA_W'({dout.rot_z, dout.rot_y, dout.rot_x});
    assign m_axis_tuser  = dout.saturated;

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> vld_reg == '0)
        else $error("pipeline holds valid data after reset");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted request did not enter the first stage");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg) && !m_axis_tready |-> !s_axis_tready)
        else $error("full pipeline accepts a request during a stall");

    a_count_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)
        |=> $countones(vld_reg) == $past($countones(vld_reg)))
        else $error("item lost or created inside the pipeline");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] && rdy[3] |=> vld_reg[3])
        else $error("stage three item was dropped");

endmodule
